/* hw/rtl/ih_pkg.sv */
// shared types and constants for the integral histogram
`default_nettype none
package ih_pkg;
	localparam int BINS = 8;
	localparam int MAX_WIDTH = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);
	localparam int AW = XW + YW;
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int CNT_W = 13;
	localparam int RS_W = 7;
	localparam int EDGE_W = 16;
	localparam int BIN_W = 3;
	localparam int NB_W = 4;
	localparam int DIM_W = 7;

	typedef enum logic [2:0] {
		CFG_BINS     = 3'd0,
		CFG_MODE     = 3'd1,
		CFG_EDGES_LO = 3'd2,
		CFG_EDGES_HI = 3'd3,
		CFG_WIDTH    = 3'd4,
		CFG_HEIGHT   = 3'd5
	} cfg_idx_t;

	typedef logic [BINS-1:0][CNT_W-1:0] row_t;

	typedef struct packed {
		logic [NB_W-1:0]              nb;
		logic                         uniform;
		logic [BINS-1:0][EDGE_W-1:0]  edges;
		logic [DIM_W-1:0]             w;
		logic [DIM_W-1:0]             h;
	} cfg_t;

	// pixel: addr[0] row above (read), addr[1] target (write)
	// query: corners in order lower-right, upper-right, lower-left, upper-left
	typedef struct packed {
		logic                       is_query;
		logic                       empty;
		logic [3:0][AW-1:0]         addr;
		logic [3:0]                 zero;
		logic [BINS-1:0][RS_W-1:0]  rowsum;
	} cmd_t;
endpackage
`default_nettype wire

/* hw/rtl/ih_ram.sv */
// generic single write port, registered read memory
`default_nettype none
module ih_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* hw/rtl/ih_fifo.sv */
// two-entry command queue between front and back
`default_nettype none
module ih_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire ih_pkg::cmd_t push_cmd,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output ih_pkg::cmd_t      head
);
	import ih_pkg::*;

	cmd_t       ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ih_front.sv */
// front: accepts items, bins pixels, tracks position, builds commands
`default_nettype none
module ih_front (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire ih_pkg::cfg_t               cfg,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       op,
	input  wire logic                       frame_start,
	input  wire logic signed [15:0]         sample,
	input  wire logic [5:0]                 rect_x,
	input  wire logic [5:0]                 rect_y,
	input  wire logic [6:0]                 rect_w,
	input  wire logic [6:0]                 rect_h,
	input  wire logic                       fifo_full,
	output logic                            push,
	output ih_pkg::cmd_t                    push_cmd
);
	import ih_pkg::*;

	logic [XW-1:0]             col_q;
	logic [YW-1:0]             row_q;
	logic [BINS-1:0][RS_W-1:0] rs_q;

	logic [XW-1:0]             px;
	logic [YW-1:0]             py;
	logic [XW-1:0]             col_n;
	logic [YW-1:0]             row_n;
	logic [BINS-1:0][RS_W-1:0] rs_n;
	logic                      hit;
	logic [BIN_W-1:0]          bin;
	cmd_t                      cmd;

	assign in_ready = !fifo_full;
	assign push = in_valid && in_ready;
	assign push_cmd = cmd;

	// binning
	always_comb begin
		logic signed [16:0] v;
		logic signed [16:0] e0;
		logic signed [16:0] e1;
		logic signed [16:0] etop;
		logic [16:0]        diff;
		logic [16:0]        span;
		logic [18:0]        rem;
		logic [18:0]        dsh;
		logic [BIN_W-1:0]   q;
		logic [NB_W-1:0]    n;
		logic [BIN_W-1:0]   top;
		v = 17'(sample);
		e0 = 17'($signed(cfg.edges[0]));
		e1 = 17'($signed(cfg.edges[1]));
		top = BIN_W'(cfg.nb - NB_W'(1));
		etop = 17'($signed(cfg.edges[top]));
		diff = 17'(v - e0);
		span = 17'(e1 - e0);
		rem = 19'(diff[15:0]) * 19'(cfg.nb);
		q = '0;
		for (int i = BIN_W - 1; i >= 0; i--) begin
			dsh = 19'(span[15:0]) << i;
			if (rem >= dsh) begin
				rem = rem - dsh;
				q[i] = 1'b1;
			end
		end
		n = '0;
		for (int k = 0; k < BINS; k++) begin
			if ((NB_W'(k) < cfg.nb) && ($signed(17'($signed(cfg.edges[k]))) <= v))
				n = n + NB_W'(1);
		end
		if (cfg.uniform) begin
			hit = (v >= e0) && (v < e1);
			bin = q;
		end else begin
			hit = (v >= e0) && (v < etop);
			bin = BIN_W'(n - NB_W'(1));
		end
	end

	// position and row sums
	always_comb begin
		logic [DIM_W-1:0] cx;
		logic [DIM_W-1:0] cy;
		logic [DIM_W-1:0] nx;
		logic [DIM_W-1:0] ny;
		cx = DIM_W'(col_q);
		cy = DIM_W'(row_q);
		if (frame_start) begin
			cx = '0;
			cy = '0;
		end
		if (cx >= cfg.w) begin
			cx = '0;
			cy = cy + DIM_W'(1);
		end
		if (cy >= cfg.h)
			cy = '0;
		px = cx[XW-1:0];
		py = cy[YW-1:0];
		nx = cx + DIM_W'(1);
		ny = cy;
		if (nx >= cfg.w) begin
			nx = '0;
			ny = (cy + DIM_W'(1) >= cfg.h) ? '0 : cy + DIM_W'(1);
		end
		col_n = nx[XW-1:0];
		row_n = ny[YW-1:0];
		for (int b = 0; b < BINS; b++) begin
			rs_n[b] = (px == '0) ? '0 : rs_q[b];
			if (hit && (bin == BIN_W'(b)))
				rs_n[b] = rs_n[b] + RS_W'(1);
		end
	end

	// command build
	always_comb begin
		logic [7:0]    x1;
		logic [7:0]    y1;
		logic [XW-1:0] xa;
		logic [XW-1:0] xb;
		logic [YW-1:0] ya;
		logic [YW-1:0] yb;
		x1 = 8'(rect_x) + 8'(rect_w);
		y1 = 8'(rect_y) + 8'(rect_h);
		if (x1 > 8'(cfg.w))
			x1 = 8'(cfg.w);
		if (y1 > 8'(cfg.h))
			y1 = 8'(cfg.h);
		xb = XW'(x1 - 8'd1);
		yb = YW'(y1 - 8'd1);
		xa = XW'(rect_x - 6'd1);
		ya = YW'(rect_y - 6'd1);
		cmd = '0;
		cmd.is_query = op;
		if (op) begin
			cmd.empty = (8'(rect_x) >= x1) || (8'(rect_y) >= y1);
			cmd.addr[0] = {yb, xb};
			cmd.addr[1] = {ya, xb};
			cmd.addr[2] = {yb, xa};
			cmd.addr[3] = {ya, xa};
			cmd.zero[0] = 1'b0;
			cmd.zero[1] = (rect_y == '0);
			cmd.zero[2] = (rect_x == '0);
			cmd.zero[3] = (rect_y == '0) || (rect_x == '0);
		end else begin
			cmd.addr[0] = {YW'(py - YW'(1)), px};
			cmd.addr[1] = {py, px};
			cmd.zero[0] = (py == '0);
			cmd.rowsum = rs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rs_q <= '0;
		end else if (push && !op) begin
			col_q <= col_n;
			row_q <= row_n;
			rs_q <= rs_n;
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/ih_back.sv */
// back: updates the area table and answers rectangle queries
`default_nettype none
module ih_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire ih_pkg::cfg_t cfg,
	input  wire logic         head_valid,
	input  wire ih_pkg::cmd_t head,
	output logic              pop,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [2:0]        bin_index,
	output logic [12:0]       count,
	output logic              last
);
	import ih_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_PIX  = 4'b0010,
		S_QRD  = 4'b0100,
		S_QOUT = 4'b1000
	} state_t;

	state_t                  state_q;
	cmd_t                    cmd_q;
	logic [2:0]              cnt_q;
	logic [BIN_W-1:0]        bin_q;
	logic signed [14:0]      acc_q [BINS];
	logic                    byp_q;
	row_t                    byp_data_q;
	logic                    out_valid_q;
	logic [BIN_W-1:0]        out_bin_q;
	logic [CNT_W-1:0]        out_cnt_q;
	logic                    out_last_q;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	row_t                    wr_data;
	row_t                    ram_rdata;
	row_t                    rdata;
	logic [1:0]              corner;
	logic                    load_out;
	logic                    bin_last;
	logic [CNT_W-1:0]        sat_cnt;

	assign pop = ((state_q == S_IDLE) || (state_q == S_PIX)) && head_valid;
	assign rd_en = pop || ((state_q == S_QRD) && (cnt_q <= 3'd3));
	assign rd_addr = pop ? head.addr[0] : cmd_q.addr[cnt_q[1:0]];
	assign wr_en = (state_q == S_PIX);
	assign rdata = byp_q ? byp_data_q : ram_rdata;
	assign corner = cnt_q[1:0] - 2'd1;
	assign load_out = (state_q == S_QOUT) && (!out_valid_q || out_ready);
	assign bin_last = ({1'b0, bin_q} == (cfg.nb - NB_W'(1)));

	always_comb begin
		for (int b = 0; b < BINS; b++)
			wr_data[b] = (cmd_q.zero[0] ? CNT_W'(0) : rdata[b]) + CNT_W'(cmd_q.rowsum[b]);
	end

	always_comb begin
		logic signed [14:0] a;
		a = acc_q[bin_q];
		if (cmd_q.empty)
			sat_cnt = '0;
		else if ((a < 15'sd0) || (a > 15'sd8191))
			sat_cnt = CNT_W'(8191);
		else
			sat_cnt = a[CNT_W-1:0];
	end

	ih_ram #(
		.WIDTH(BINS * CNT_W),
		.DEPTH(DEPTH)
	) u_area (
		.clk  (clk),
		.we   (wr_en),
		.waddr(cmd_q.addr[1]),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		byp_data_q <= wr_data;
		if (pop)
			cmd_q <= head;
		if (state_q == S_QRD) begin
			for (int b = 0; b < BINS; b++) begin
				logic signed [14:0] t;
				t = cmd_q.zero[corner] ? 15'sd0 : $signed(15'(rdata[b]));
				if ((corner == 2'd1) || (corner == 2'd2))
					t = -t;
				acc_q[b] <= ((cnt_q == 3'd1) ? 15'sd0 : acc_q[b]) + t;
			end
		end
		if (load_out) begin
			out_bin_q <= bin_q;
			out_cnt_q <= sat_cnt;
			out_last_q <= bin_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			bin_q <= '0;
			byp_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			byp_q <= wr_en && rd_en && (rd_addr == cmd_q.addr[1]);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE, S_PIX: begin
					if (pop) begin
						if (head.is_query) begin
							state_q <= S_QRD;
							cnt_q <= 3'd1;
						end else begin
							state_q <= S_PIX;
						end
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_QRD: begin
					if (cnt_q == 3'd4) begin
						state_q <= S_QOUT;
						bin_q <= '0;
					end else begin
						cnt_q <= cnt_q + 3'd1;
					end
				end
				S_QOUT: begin
					if (load_out) begin
						bin_q <= bin_q + BIN_W'(1);
						if (bin_last)
							state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = out_bin_q;
	assign count = out_cnt_q;
	assign last = out_last_q;
endmodule
`default_nettype wire

/* hw/rtl/integral_histogram.sv */
// integral histogram top level: configuration registers, front, queue and back
// Usage:
//   Items enter on in_valid/in_ready. op 0 is a pixel in raster order, op 1 a
//   rectangle query. Pixels return nothing; a query returns one item per bin in
//   use on out_valid/out_ready, bins in order, last set on the final bin.
//   Configuration is written on cfg_valid/cfg_ready (always ready), register
//   index on cfg_index, value on cfg_data. Write only while the block is idle; it does not check.
// Timing:
//   A pixel reads the row above and writes its entry in the next cycle; the two
//   steps of neighboring pixels overlap, so pixels sustain one item per cycle
//   while no query is in progress. A query reads its four table corners in turn,
//   then loads one result per bin into the output as the receiver takes them.
//   A two-entry queue sits between the front and the table sequencer.
// Reset:
//   Clears the position, row sums, queue and output; registers return to 8 bins,
//   uniform mode, zero edges and a 64 x 64 image. The table is not cleared.
// Stall:
//   A stalled receiver holds the result register; the queue then fills and
//   in_ready drops until results drain.
`default_nettype none
module integral_histogram (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               op,
	input  wire logic               frame_start,
	input  wire logic signed [15:0] sample,
	input  wire logic [5:0]         rect_x,
	input  wire logic [5:0]         rect_y,
	input  wire logic [6:0]         rect_w,
	input  wire logic [6:0]         rect_h,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              bin_index,
	output logic [12:0]             count,
	output logic                    last,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [63:0]        cfg_data
);
	import ih_pkg::*;

	logic [NB_W-1:0]  bins_q;
	logic             mode_q;
	logic [63:0]      edges_lo_q;
	logic [63:0]      edges_hi_q;
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	cfg_t             cfg;
	logic             fifo_full;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	logic             head_valid;
	cmd_t             head;

	assign cfg_ready = 1'b1;

	always_comb begin
		cfg.nb = (bins_q == '0) ? NB_W'(1) : ((bins_q > NB_W'(BINS)) ? NB_W'(BINS) : bins_q);
		cfg.uniform = mode_q;
		cfg.edges = {edges_hi_q, edges_lo_q};
		cfg.w = (width_q == '0) ? DIM_W'(1)
			: ((width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q);
		cfg.h = (height_q == '0) ? DIM_W'(1)
			: ((height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q <= NB_W'(BINS);
			mode_q <= 1'b1;
			edges_lo_q <= '0;
			edges_hi_q <= '0;
			width_q <= DIM_W'(MAX_WIDTH);
			height_q <= DIM_W'(MAX_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BINS:     bins_q <= cfg_data[NB_W-1:0];
				CFG_MODE:     mode_q <= cfg_data[0];
				CFG_EDGES_LO: edges_lo_q <= cfg_data;
				CFG_EDGES_HI: edges_hi_q <= cfg_data;
				CFG_WIDTH:    width_q <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:   height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	ih_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.frame_start(frame_start),
		.sample     (sample),
		.rect_x     (rect_x),
		.rect_y     (rect_y),
		.rect_w     (rect_w),
		.rect_h     (rect_h),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	ih_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (fifo_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	ih_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.bin_index (bin_index),
		.count     (count),
		.last      (last)
	);
endmodule
`default_nettype wire
